### design/ibs_pkg.sv
// Shared types and register map of the information frame byte stuffer.
package ibs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegFlag      = 3'd0,
    RegAddress   = 3'd1,
    RegEscape    = 3'd2,
    RegFlagSub   = 3'd3,
    RegEscSub    = 3'd4,
    RegCtrlSeq0  = 3'd5,
    RegCtrlSeq1  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] flag_value;
    logic [ByteW-1:0] address_value;
    logic [ByteW-1:0] escape_value;
    logic [ByteW-1:0] flag_substitute;
    logic [ByteW-1:0] escape_substitute;
    logic [ByteW-1:0] control_seq_zero;
    logic [ByteW-1:0] control_seq_one;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    flag_value:        8'd126,
    address_value:     8'd3,
    escape_value:      8'd125,
    flag_substitute:   8'd94,
    escape_substitute: 8'd93,
    control_seq_zero:  8'd0,
    control_seq_one:   8'd64
  };

endpackage

### design/ibs_cfg_regs.sv
// Configuration register file of the byte stuffer, write only.
module ibs_cfg_regs
  import ibs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFlag:     cfg_d.flag_value        = cfg_wdata_i;
        RegAddress:  cfg_d.address_value     = cfg_wdata_i;
        RegEscape:   cfg_d.escape_value      = cfg_wdata_i;
        RegFlagSub:  cfg_d.flag_substitute   = cfg_wdata_i;
        RegEscSub:   cfg_d.escape_substitute = cfg_wdata_i;
        RegCtrlSeq0: cfg_d.control_seq_zero  = cfg_wdata_i;
        RegCtrlSeq1: cfg_d.control_seq_one   = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/info_frame_byte_stuffer.sv
// Accepted beats go to the work register, their bytes then to the output register.
// Throughput: one line byte per cycle unless m_axis_tready_i stalls the output;
//   an item causes 1 line byte for a plain mid-frame byte, up to 9 for a one-byte
//   frame; the rate is set by the single output byte register.
// Next item is taken in the cycle its predecessor's last byte is loaded.
// Reset: frame state and BCC cleared, registers to defaults, output empty.
module info_frame_byte_stuffer
  import ibs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ByteW-1:0]   s_axis_tdata_i,   // [7:0] payload_byte
  input  logic               s_axis_tlast_i,   // frame_end
  input  logic               s_axis_tuser_i,   // [0] seq_bit
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [ByteW-1:0]   m_axis_tdata_o,   // [7:0] line_byte
  output logic               m_axis_tlast_o,   // run_last
  output logic               m_axis_tuser_o,   // [0] frame_done
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i
);

  localparam int unsigned NumSlots = 9;
  localparam int unsigned SlotW    = 4;

  typedef enum logic [SlotW-1:0] {
    SlotFlagOpen  = 4'd0,
    SlotAddr      = 4'd1,
    SlotCtrl      = 4'd2,
    SlotBcc1      = 4'd3,
    SlotData      = 4'd4,
    SlotDataSub   = 4'd5,
    SlotBcc2      = 4'd6,
    SlotBcc2Sub   = 4'd7,
    SlotFlagClose = 4'd8
  } slot_e;

  cfg_t cfg;

  ibs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // frame state
  logic             inside_q;
  logic [ByteW-1:0] bcc_q;

  // work register: pending slots of the current item
  logic [NumSlots-1:0] mask_q, mask_d;
  logic [ByteW-1:0]    data_q, bcc2_q;
  logic                seq_q, data_fsub_q, bcc_fsub_q;

  // output register
  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_last_q, out_done_q;

  logic                in_acc, out_free, emit;
  logic [NumSlots-1:0] low_bit, mask_rest;
  logic [SlotW-1:0]    slot;
  logic [ByteW-1:0]    ctrl, emit_byte;
  logic [ByteW-1:0]    bcc_new;
  logic                d_flag, d_esc, b_flag, b_esc;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign emit     = (mask_q != '0) && out_free;
  assign low_bit  = mask_q & (~mask_q + NumSlots'(1));
  assign mask_rest = mask_q & ~low_bit;

  assign s_axis_tready_o = (mask_q == '0) || (emit && (mask_rest == '0));
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    slot = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (low_bit[i]) slot = SlotW'(i);
    end
  end

  assign bcc_new = (inside_q ? bcc_q : '0) ^ s_axis_tdata_i;
  assign d_flag  = s_axis_tdata_i == cfg.flag_value;
  assign d_esc   = s_axis_tdata_i == cfg.escape_value;
  assign b_flag  = bcc_new == cfg.flag_value;
  assign b_esc   = bcc_new == cfg.escape_value;

  always_comb begin
    mask_d = emit ? mask_rest : mask_q;
    if (in_acc) begin
      mask_d = '0;
      mask_d[SlotFlagOpen]  = !inside_q;
      mask_d[SlotAddr]      = !inside_q;
      mask_d[SlotCtrl]      = !inside_q;
      mask_d[SlotBcc1]      = !inside_q;
      mask_d[SlotData]      = 1'b1;
      mask_d[SlotDataSub]   = d_flag || d_esc;
      mask_d[SlotBcc2]      = s_axis_tlast_i;
      mask_d[SlotBcc2Sub]   = s_axis_tlast_i && (b_flag || b_esc);
      mask_d[SlotFlagClose] = s_axis_tlast_i;
    end
  end

  assign ctrl = seq_q ? cfg.control_seq_one : cfg.control_seq_zero;

  always_comb begin
    unique case (slot)
      SlotFlagOpen:  emit_byte = cfg.flag_value;
      SlotAddr:      emit_byte = cfg.address_value;
      SlotCtrl:      emit_byte = ctrl;
      SlotBcc1:      emit_byte = cfg.address_value ^ ctrl;
      SlotData:      emit_byte = mask_q[SlotDataSub] ? cfg.escape_value : data_q;
      SlotDataSub:   emit_byte = data_fsub_q ? cfg.flag_substitute : cfg.escape_substitute;
      SlotBcc2:      emit_byte = mask_q[SlotBcc2Sub] ? cfg.escape_value : bcc2_q;
      SlotBcc2Sub:   emit_byte = bcc_fsub_q ? cfg.flag_substitute : cfg.escape_substitute;
      SlotFlagClose: emit_byte = cfg.flag_value;
      default:       emit_byte = cfg.flag_value;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      bcc_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (in_acc) begin
        inside_q <= !s_axis_tlast_i;
        bcc_q    <= s_axis_tlast_i ? '0 : bcc_new;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        out_last_q  <= mask_rest == '0;
        out_done_q  <= slot == SlotFlagClose;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q      <= s_axis_tdata_i;
      bcc2_q      <= bcc_new;
      seq_q       <= s_axis_tuser_i;
      data_fsub_q <= d_flag;
      bcc_fsub_q  <= b_flag;
    end
    if (emit) begin
      out_data_q <= emit_byte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_last_q)
    else $error("closing flag beat without run end");

  a_data_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> mask_q[SlotData])
    else $error("accepted item has no data slot pending");

  a_frame_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(inside_q) |-> $past(in_acc && s_axis_tlast_i))
    else $error("frame closed without a last beat");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> $stable(out_data_q))
    else $error("stalled output byte overwritten");

endmodule
